@@ rtl/dtfe_pkg.sv @@
// Shared types, constants and coding functions for the DShot telemetry frame encoder.
package dtfe_pkg;

  localparam int WORD_W      = 16;
  localparam int PAYLOAD_W   = 12;
  localparam int NIBBLE_W    = 4;
  localparam int GCR_W       = 5;
  localparam int GCR_BITS_W  = 20;
  localparam int LEVELS_W    = 21;
  localparam int PERIOD_W    = 16;
  localparam int EXT_W       = 12;
  localparam int MANT_W      = 9;
  localparam int EXP_W       = 3;

  localparam logic [PERIOD_W-1:0] IDLE_PERIOD = 16'd65408;
  localparam logic [NIBBLE_W-1:0] CSUM_MASK   = 4'hF;
  localparam int                  QUEUE_DEPTH_DEF = 2;

  // One frame word moving between stages, tagged by its valid flag.
  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] word;
  } dtfe_item_t;

  // Four-bit to five-bit group code.
  function automatic logic [GCR_W-1:0] gcr5(input logic [NIBBLE_W-1:0] nib);
    logic [GCR_W-1:0] code;
    case (nib)
      4'h0:    code = 5'b11001;
      4'h1:    code = 5'b11011;
      4'h2:    code = 5'b10010;
      4'h3:    code = 5'b10011;
      4'h4:    code = 5'b11101;
      4'h5:    code = 5'b10101;
      4'h6:    code = 5'b10110;
      4'h7:    code = 5'b10111;
      4'h8:    code = 5'b11010;
      4'h9:    code = 5'b01001;
      4'hA:    code = 5'b01010;
      4'hB:    code = 5'b01011;
      4'hC:    code = 5'b11110;
      4'hD:    code = 5'b01101;
      4'hE:    code = 5'b01110;
      4'hF:    code = 5'b01111;
      default: code = 5'b11001;
    endcase
    return code;
  endfunction

  // Packs the clamped period as a 3-bit exponent and 9-bit mantissa.
  function automatic logic [PAYLOAD_W-1:0] period_code(input logic [PERIOD_W-1:0] period,
                                                       input logic running);
    logic [PERIOD_W-1:0] p;
    logic [EXP_W-1:0]    e;
    logic [PERIOD_W-1:0] shifted;
    p = period;
    e = '0;
    if (!running || (period > IDLE_PERIOD)) begin
      p = IDLE_PERIOD;
    end
    // Scanning upward lets the highest set bit win.
    for (int b = MANT_W; b < PERIOD_W; b++) begin
      if (p[b]) begin
        e = EXP_W'(b - MANT_W + 1);
      end
    end
    shifted = p >> e;
    return {e, shifted[MANT_W-1:0]};
  endfunction

  // Appends the inverted nibble XOR checksum to the payload.
  function automatic logic [WORD_W-1:0] frame_of(input logic [PAYLOAD_W-1:0] payload);
    logic [NIBBLE_W-1:0] csum;
    csum = ~(payload[11:8] ^ payload[7:4] ^ payload[3:0]) & CSUM_MASK;
    return {payload, csum};
  endfunction

endpackage

@@ rtl/dshot_telemetry_frame_encoder_unit.sv @@
// Path: an accepted request passes the front register, the queue and the output register before its result strobe.
// Throughput: one frame per cycle; the front register, the queue and the output register
// each move one word per cycle, so busy stays low while the result side takes every strobe.
// Reset: synchronous active-low rst_n empties the front register, the queue and the strobe.
// The result receiver cannot stall; each result stands for exactly one cycle.
module dshot_telemetry_frame_encoder_unit #(
  parameter int QUEUE_DEPTH = dtfe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [dtfe_pkg::PERIOD_W-1:0]     in_commutation_period,
  input  logic                              in_motor_running,
  input  logic [dtfe_pkg::EXT_W-1:0]        in_extended_value,
  output logic                              out_valid,
  output logic [dtfe_pkg::WORD_W-1:0]       out_frame_word,
  output logic [dtfe_pkg::LEVELS_W-1:0]     out_line_levels
);

  dtfe_pkg::dtfe_item_t q_wr;
  dtfe_pkg::dtfe_item_t q_rd;
  logic                 q_full;
  logic                 q_pop;

  dtfe_front u_front (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_commutation_period (in_commutation_period),
    .in_motor_running      (in_motor_running),
    .in_extended_value     (in_extended_value),
    .q_full                (q_full),
    .q_wr                  (q_wr)
  );

  dtfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .full  (q_full),
    .rd    (q_rd),
    .pop   (q_pop)
  );

  dtfe_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .rd              (q_rd),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_frame_word  (out_frame_word),
    .out_line_levels (out_line_levels)
  );

  // Every delivered word carries a checksum that makes all four nibbles XOR to ones.
  a_checksum : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_frame_word[15:12] ^ out_frame_word[11:8] ^
                    out_frame_word[7:4] ^ out_frame_word[3:0]) == dtfe_pkg::CSUM_MASK))
    else $error("frame checksum mismatch");

  // The first line level is always high.
  a_lead_level : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_line_levels[dtfe_pkg::LEVELS_W-1])
    else $error("leading line level low");

  // With the back stage draining every cycle, the front never has to hold off a request.
  a_never_busy : assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("front stage stalled");

  // An accepted request produces its result strobe after the front register, the queue and the output register.
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("result strobe missing");

endmodule

@@ rtl/dtfe_front.sv @@
// Front stage: accepts a request, selects the payload and forms the frame word.
module dtfe_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [dtfe_pkg::PERIOD_W-1:0]      in_commutation_period,
  input  logic                               in_motor_running,
  input  logic [dtfe_pkg::EXT_W-1:0]         in_extended_value,
  input  logic                               q_full,
  output dtfe_pkg::dtfe_item_t               q_wr
);

  logic                            valid_r, valid_nxt;
  logic [dtfe_pkg::WORD_W-1:0]     word_r, word_nxt;
  logic [dtfe_pkg::PAYLOAD_W-1:0]  payload;
  logic                            accept;
  logic                            pushed;

  always_comb begin
    if (in_extended_value != '0) begin
      payload = in_extended_value;
    end else begin
      payload = dtfe_pkg::period_code(in_commutation_period, in_motor_running);
    end
  end

  assign pushed = valid_r && !q_full;
  assign busy   = valid_r && q_full;
  assign accept = start && !busy;

  always_comb begin
    valid_nxt = valid_r && !pushed;
    word_nxt  = word_r;
    if (accept) begin
      valid_nxt = 1'b1;
      word_nxt  = dtfe_pkg::frame_of(payload);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign q_wr.valid = pushed;
  assign q_wr.word  = word_r;

endmodule

@@ rtl/dtfe_queue.sv @@
// Short FIFO of frame words between the front and back stages.
module dtfe_queue #(
  parameter int DEPTH = dtfe_pkg::QUEUE_DEPTH_DEF  // at least 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dtfe_pkg::dtfe_item_t wr,
  output logic                 full,
  output dtfe_pkg::dtfe_item_t rd,
  input  logic                 pop
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic [dtfe_pkg::WORD_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]            wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]            rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic                        do_push;
  logic                        do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign do_push = wr.valid && !full;
  assign do_pop  = pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr.word;
    end
  end

  assign rd.valid = (count_r != '0);
  assign rd.word  = mem_r[rd_ptr_r];

endmodule

@@ rtl/dtfe_back.sv @@
// Back stage: group-codes the frame word, NRZI-codes it and drives the result strobe.
module dtfe_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dtfe_pkg::dtfe_item_t              rd,
  output logic                              pop,
  output logic                              out_valid,
  output logic [dtfe_pkg::WORD_W-1:0]       out_frame_word,
  output logic [dtfe_pkg::LEVELS_W-1:0]     out_line_levels
);

  logic [dtfe_pkg::GCR_BITS_W-1:0] gcr;
  logic [dtfe_pkg::LEVELS_W-1:0]   levels;
  logic                            valid_r, valid_nxt;
  logic [dtfe_pkg::WORD_W-1:0]     word_r;
  logic [dtfe_pkg::LEVELS_W-1:0]   levels_r;

  // The receiver never stalls, so the head of the queue is taken whenever present.
  assign pop       = rd.valid;
  assign valid_nxt = rd.valid;

  assign gcr = {dtfe_pkg::gcr5(rd.word[15:12]), dtfe_pkg::gcr5(rd.word[11:8]),
                dtfe_pkg::gcr5(rd.word[7:4]),   dtfe_pkg::gcr5(rd.word[3:0])};

  // Each level is the leading high level toggled by every code bit sent before it.
  assign levels[dtfe_pkg::GCR_BITS_W] = 1'b1;
  for (genvar i = 0; i < dtfe_pkg::GCR_BITS_W; i++) begin : g_nrzi
    assign levels[i] = ~(^gcr[dtfe_pkg::GCR_BITS_W-1:i]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.valid) begin
      word_r   <= rd.word;
      levels_r <= levels;
    end
  end

  assign out_valid       = valid_r;
  assign out_frame_word  = word_r;
  assign out_line_levels = levels_r;

endmodule
